[src/trpl_pkg.sv]
// trpl_pkg: shared constants and types for the tagged region point lookup unit
// no dependencies
`timescale 1ns / 1ps
package trpl_pkg;
  localparam int DefMaxEdges   = 256;
  localparam int DefMaxRegions = 16;
  localparam int CoordW        = 16;
  localparam int TagW          = 16;
  localparam int StatusW       = 2;
  localparam int CmdW          = 2;
  localparam int QuotW         = 33;

  localparam logic [CmdW-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CmdW-1:0] CMD_QUERY = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CmdW-1:0] CMD_NOP   = 2'd3;

  localparam logic [StatusW-1:0] ST_OK          = 2'd0;
  localparam logic [StatusW-1:0] ST_EDGE_FULL   = 2'd1;
  localparam logic [StatusW-1:0] ST_REGION_FULL = 2'd2;
  localparam logic [StatusW-1:0] ST_ZERO_TAG    = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic latch_in;     // capture input item
    logic clear_tabs;   // empty both tables
    logic rsearch_init; // start region tag search
    logic rsearch_step; // compare next region tag
    logic store_edge;   // write edge and maybe new region
    logic qinit;        // clear parity, edge pointer
    logic rd_edge;      // issue edge read
    logic eval_edge;    // set up crossing test from read data
    logic div_start;    // start divider
    logic edge_done;    // apply parity and advance
    logic pscan_init;
    logic pscan_step;
    logic emit;         // drive result strobe
  } trpl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic zero_tag;
    logic edge_full;
    logic rsearch_done;
    logic tag_found;
    logic region_full;
    logic edges_done;
    logic crosses;     // endpoints straddle cy
    logic div_busy;
    logic pscan_done;
  } trpl_sts_t;
endpackage

[src/tagged_region_point_lookup_unit.sv]
// channel  | handshake            | ports
// input    | start & !busy        | in_cmd, in_edge_tag, in_edge_*, in_box_*
// result   | out_valid, one cycle | out_region_tag, out_status
// load and clear run from transfer to result strobe, then busy drops and the
// unit is idle, ready for the next transfer.
// a query reads and evaluates each edge, runs the 33-step divider on each
// crossing edge, then scans the regions (at least one) for odd parity.
// reset empties both tables at once; no clearing pass.
// the receiver cannot stall: the result strobe lasts one cycle.
// uses trpl_pkg, trpl_ctrl, trpl_datapath
`timescale 1ns / 1ps
module tagged_region_point_lookup_unit #(
  parameter int MaxEdges   = trpl_pkg::DefMaxEdges,
  parameter int MaxRegions = trpl_pkg::DefMaxRegions
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [trpl_pkg::CmdW-1:0]          in_cmd,
  input  logic [trpl_pkg::TagW-1:0]          in_edge_tag,
  input  logic signed [trpl_pkg::CoordW-1:0] in_edge_x1,
  input  logic signed [trpl_pkg::CoordW-1:0] in_edge_y1,
  input  logic signed [trpl_pkg::CoordW-1:0] in_edge_x2,
  input  logic signed [trpl_pkg::CoordW-1:0] in_edge_y2,
  input  logic signed [trpl_pkg::CoordW-1:0] in_box_left,
  input  logic signed [trpl_pkg::CoordW-1:0] in_box_right,
  input  logic signed [trpl_pkg::CoordW-1:0] in_box_top,
  input  logic signed [trpl_pkg::CoordW-1:0] in_box_bottom,
  output logic                               out_valid,
  output logic [trpl_pkg::TagW-1:0]          out_region_tag,
  output logic [trpl_pkg::StatusW-1:0]       out_status
);
  import trpl_pkg::*;
  trpl_cmd_t ctl;
  trpl_sts_t sts;
  logic [StatusW-1:0] st_code;

  trpl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .ctl(ctl), .sts(sts), .st_code(st_code)
  );

  trpl_datapath #(.MaxEdges(MaxEdges), .MaxRegions(MaxRegions)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_cmd(in_cmd), .in_edge_tag(in_edge_tag),
    .in_edge_x1(in_edge_x1), .in_edge_y1(in_edge_y1),
    .in_edge_x2(in_edge_x2), .in_edge_y2(in_edge_y2),
    .in_box_left(in_box_left), .in_box_right(in_box_right),
    .in_box_top(in_box_top), .in_box_bottom(in_box_bottom),
    .st_code(st_code), .res_tag(out_region_tag)
  );

  assign out_valid  = ctl.emit;
  assign out_status = ctl.emit ? st_code : ST_OK;
endmodule

[src/trpl_div.sv]
// trpl_div: restoring signed divider, one quotient bit per cycle, truncating
// uses trpl_pkg
`timescale 1ns / 1ps
module trpl_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [trpl_pkg::QuotW-1:0] dividend,
  input  logic signed [trpl_pkg::CoordW:0]  divisor,
  output logic                         busy,
  output logic signed [trpl_pkg::QuotW-1:0] quotient
);
  import trpl_pkg::*;
  localparam int CntW = $clog2(QuotW + 1);

  logic [QuotW-1:0]  rem_r, rem_nxt;
  logic [QuotW-1:0]  quo_r, quo_nxt;
  logic [CoordW:0]   den_r, den_nxt;
  logic              neg_r, neg_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [QuotW:0]    trial;
  logic [QuotW-1:0]  shifted;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    shifted  = {rem_r[QuotW-2:0], quo_r[QuotW-1]};
    trial    = {1'b0, shifted} - {{(QuotW-CoordW){1'b0}}, den_r};
    if (start) begin
      quo_nxt  = dividend[QuotW-1] ? QuotW'(-dividend) : dividend;
      den_nxt  = divisor[CoordW] ? (CoordW+1)'(-divisor) : divisor;
      neg_nxt  = dividend[QuotW-1] ^ divisor[CoordW];
      rem_nxt  = '0;
      cnt_nxt  = CntW'(QuotW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[QuotW]) rem_nxt = trial[QuotW-1:0];
      else rem_nxt = shifted;
      quo_nxt = {quo_r[QuotW-2:0], ~trial[QuotW]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? QuotW'(-quo_r) : quo_r;
endmodule

[src/trpl_datapath.sv]
// trpl_datapath: edge and region tables, crossing test, parity scan
// uses trpl_pkg and trpl_div
`timescale 1ns / 1ps
module trpl_datapath #(
  parameter int MaxEdges   = trpl_pkg::DefMaxEdges,
  parameter int MaxRegions = trpl_pkg::DefMaxRegions
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  trpl_pkg::trpl_cmd_t               ctl,
  output trpl_pkg::trpl_sts_t               sts,
  input  logic [trpl_pkg::CmdW-1:0]         in_cmd,
  input  logic [trpl_pkg::TagW-1:0]         in_edge_tag,
  input  logic signed [trpl_pkg::CoordW-1:0] in_edge_x1,
  input  logic signed [trpl_pkg::CoordW-1:0] in_edge_y1,
  input  logic signed [trpl_pkg::CoordW-1:0] in_edge_x2,
  input  logic signed [trpl_pkg::CoordW-1:0] in_edge_y2,
  input  logic signed [trpl_pkg::CoordW-1:0] in_box_left,
  input  logic signed [trpl_pkg::CoordW-1:0] in_box_right,
  input  logic signed [trpl_pkg::CoordW-1:0] in_box_top,
  input  logic signed [trpl_pkg::CoordW-1:0] in_box_bottom,
  input  logic [trpl_pkg::StatusW-1:0]      st_code,
  output logic [trpl_pkg::TagW-1:0]         res_tag
);
  import trpl_pkg::*;
  localparam int EAW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int ECW = $clog2(MaxEdges + 1);
  localparam int RAW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
  localparam int RCW = $clog2(MaxRegions + 1);
  // search index runs one past the region count
  localparam int RIW = $clog2(MaxRegions + 2);
  localparam int EntW = 4 * CoordW + RAW;

  logic [CmdW-1:0]          cmd_r;
  logic [TagW-1:0]          tag_r;
  logic signed [CoordW-1:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [CoordW-1:0] cx_r, cy_r;
  logic [ECW-1:0]           ecount_r;
  logic [RCW-1:0]           rcount_r;
  logic [RIW-1:0]           ridx_r;
  logic                     found_r;
  logic [RAW-1:0]           slot_r;
  logic [ECW-1:0]           eptr_r;
  logic [MaxRegions-1:0]    par_r;
  logic [TagW-1:0]          tag_rd_r;

  logic [EntW-1:0]          emem [MaxEdges];
  logic [TagW-1:0]          rmem [MaxRegions];
  logic [EntW-1:0]          ent_r;

  // working edge
  logic signed [CoordW-1:0] ex1_r;
  logic [RAW-1:0]           eslot_r;
  logic                     cross_r;
  logic signed [QuotW-1:0]  dividend;
  logic signed [CoordW:0]   divisor;
  logic signed [CoordW-1:0] rx1, ry1, rx2, ry2;
  logic [RAW-1:0]           rslot;
  logic                     div_busy;
  logic signed [QuotW-1:0]  quot;
  logic signed [QuotW:0]    xi;
  logic signed [CoordW:0]   sumx, sumy;
  logic signed [QuotW-1:0]  prod_r;
  logic signed [CoordW:0]   dy_r;

  assign {rx1, ry1, rx2, ry2, rslot} = ent_r;
  assign sumx = CoordW'(0) + in_box_left + in_box_right;
  assign sumy = CoordW'(0) + in_box_top + in_box_bottom;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecount_r <= '0;
      rcount_r <= '0;
    end else begin
      if (ctl.clear_tabs) begin
        ecount_r <= '0;
        rcount_r <= '0;
      end
      if (ctl.store_edge) begin
        ecount_r <= ecount_r + 1'b1;
        if (!found_r) rcount_r <= rcount_r + 1'b1;
      end
    end
    if (ctl.latch_in) begin
      cmd_r <= in_cmd;
      tag_r <= in_edge_tag;
      x1_r  <= in_edge_x1;
      y1_r  <= in_edge_y1;
      x2_r  <= in_edge_x2;
      y2_r  <= in_edge_y2;
      // truncating halving of exact sums
      cx_r  <= CoordW'((sumx + (CoordW+1)'(sumx[CoordW])) >>> 1);
      cy_r  <= CoordW'((sumy + (CoordW+1)'(sumy[CoordW])) >>> 1);
    end
    if (ctl.rsearch_init) begin
      ridx_r  <= '0;
      found_r <= 1'b0;
    end else if (ctl.rsearch_step) begin
      if (tag_rd_r == tag_r && ridx_r != '0 && !found_r) begin
        found_r <= 1'b1;
        slot_r  <= RAW'(ridx_r - 1'b1);
      end
      if (!found_r) ridx_r <= ridx_r + 1'b1;
    end
    // registered tag read; the compare sees the entry at ridx_r - 1
    tag_rd_r <= rmem[RAW'(ctl.rsearch_init ? '0 : ridx_r)];
    if (ctl.store_edge) begin
      emem[EAW'(ecount_r)] <= {x1_r, y1_r, x2_r, y2_r, found_r ? slot_r : RAW'(rcount_r)};
      if (!found_r) rmem[RAW'(rcount_r)] <= tag_r;
    end
    if (ctl.qinit) begin
      eptr_r <= '0;
      par_r  <= '0;
    end
    if (ctl.rd_edge) ent_r <= emem[EAW'(eptr_r)];
    if (ctl.eval_edge) begin
      cross_r <= (ry1 > cy_r) != (ry2 > cy_r);
      ex1_r   <= rx1;
      eslot_r <= rslot;
      prod_r  <= QuotW'((CoordW+1)'(cy_r) - (CoordW+1)'(ry1)) *
                 QuotW'((CoordW+1)'(rx2) - (CoordW+1)'(rx1));
      dy_r    <= (CoordW+1)'(ry2) - (CoordW+1)'(ry1);
    end
    if (ctl.edge_done) begin
      if (cross_r && xi < (QuotW+1)'(cx_r)) par_r[eslot_r] <= ~par_r[eslot_r];
      eptr_r <= eptr_r + 1'b1;
    end
    if (ctl.pscan_init) begin
      ridx_r  <= '0;
      found_r <= 1'b0;
    end else if (ctl.pscan_step && !found_r) begin
      if (par_r[RAW'(ridx_r)]) found_r <= 1'b1;
      else ridx_r <= ridx_r + 1'b1;
    end
  end

  assign dividend = prod_r;
  assign divisor  = dy_r;
  assign xi = (QuotW+1)'(ex1_r) + (QuotW+1)'(quot);

  trpl_div u_div (
    .clk(clk), .rst_n(rst_n), .start(ctl.div_start),
    .dividend(dividend), .divisor(divisor), .busy(div_busy), .quotient(quot)
  );

  always_comb begin
    sts.cmd          = cmd_r;
    sts.zero_tag     = (tag_r == '0);
    sts.edge_full    = (ecount_r >= ECW'(MaxEdges));
    sts.rsearch_done = found_r || (ridx_r > rcount_r);
    sts.tag_found    = found_r;
    sts.region_full  = (rcount_r >= RCW'(MaxRegions));
    sts.edges_done   = (eptr_r >= ecount_r);
    sts.crosses      = cross_r;
    sts.div_busy     = div_busy;
    sts.pscan_done   = found_r || (ridx_r >= rcount_r);
  end

  // ctl.emit marks that res_tag is sampled by the top level
  assign res_tag = (ctl.emit && st_code == ST_OK && cmd_r == CMD_QUERY && found_r)
                   ? rmem[RAW'(ridx_r)] : '0;
endmodule

[src/trpl_ctrl.sv]
// trpl_ctrl: command sequencer for load, query and clear
// uses trpl_pkg
`timescale 1ns / 1ps
module trpl_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  output trpl_pkg::trpl_cmd_t          ctl,
  input  trpl_pkg::trpl_sts_t          sts,
  output logic [trpl_pkg::StatusW-1:0] st_code
);
  import trpl_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_RSRCH = 4'd2, S_STORE = 4'd3,
                         S_QRD = 4'd4, S_QEVAL = 4'd5, S_QDIV = 4'd6, S_QWAIT = 4'd7,
                         S_QAPPLY = 4'd8, S_PSCAN = 4'd9, S_DONE = 4'd10,
                         S_RWAIT = 4'd11, S_PINIT = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [StatusW-1:0] st_r, st_nxt;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: if (start) begin
        ctl.latch_in = 1'b1;
        state_nxt    = S_DEC;
      end
      S_DEC: begin
        st_nxt = ST_OK;
        case (sts.cmd)
          CMD_LOAD: begin
            if (sts.zero_tag) begin st_nxt = ST_ZERO_TAG; state_nxt = S_DONE; end
            else if (sts.edge_full) begin st_nxt = ST_EDGE_FULL; state_nxt = S_DONE; end
            else begin ctl.rsearch_init = 1'b1; state_nxt = S_RWAIT; end
          end
          CMD_QUERY: begin ctl.qinit = 1'b1; state_nxt = S_QRD; end
          CMD_CLEAR: begin ctl.clear_tabs = 1'b1; state_nxt = S_DONE; end
          default: state_nxt = S_DONE;
        endcase
      end
      S_RWAIT: begin ctl.rsearch_step = 1'b1; state_nxt = S_RSRCH; end
      S_RSRCH: begin
        if (sts.rsearch_done) begin
          if (!sts.tag_found && sts.region_full) begin
            st_nxt = ST_REGION_FULL; state_nxt = S_DONE;
          end else state_nxt = S_STORE;
        end else ctl.rsearch_step = 1'b1;
      end
      S_STORE: begin ctl.store_edge = 1'b1; state_nxt = S_DONE; end
      S_QRD: begin
        if (sts.edges_done) begin ctl.pscan_init = 1'b1; state_nxt = S_PINIT; end
        else begin ctl.rd_edge = 1'b1; state_nxt = S_QEVAL; end
      end
      S_QEVAL: begin ctl.eval_edge = 1'b1; state_nxt = S_QDIV; end
      S_QDIV: begin
        if (sts.crosses) begin ctl.div_start = 1'b1; state_nxt = S_QWAIT; end
        else begin ctl.edge_done = 1'b1; state_nxt = S_QRD; end
      end
      S_QWAIT: if (!sts.div_busy) state_nxt = S_QAPPLY;
      S_QAPPLY: begin ctl.edge_done = 1'b1; state_nxt = S_QRD; end
      S_PINIT: begin ctl.pscan_step = 1'b1; state_nxt = S_PSCAN; end
      S_PSCAN: begin
        if (sts.pscan_done) state_nxt = S_DONE;
        else ctl.pscan_step = 1'b1;
      end
      S_DONE: begin ctl.emit = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  assign busy    = (state_r != S_IDLE);
  assign st_code = st_r;
endmodule

[src/trpl_checker.sv]
// trpl_checker: port-level checks for the lookup unit
// uses trpl_pkg; bound to tagged_region_point_lookup_unit
`timescale 1ns / 1ps
module trpl_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [trpl_pkg::TagW-1:0]    out_region_tag,
  input logic [trpl_pkg::StatusW-1:0] out_status
);
  import trpl_pkg::*;

  // a transfer in makes the unit busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("not busy after transfer");

  // result ends the item
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");

  // no result while idle
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  // an error status never carries a tag
  a_err_no_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_region_tag == '0)
    else $error("tag with error status");
endmodule

bind tagged_region_point_lookup_unit trpl_checker u_trpl_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_region_tag(out_region_tag), .out_status(out_status)
);
